// ===== rtl/sspe_pkg.sv =====
// ----------------------------------------------------------------------------
// sspe_pkg - shared definitions for the smooth scroll position easer
// Request codes, configuration register indices, field widths and the
// fixed-point constant used for the divide-by-five in the easing step.
// ----------------------------------------------------------------------------
package sspe_pkg;

  // Field widths
  localparam int unsigned ReqW     = 3;
  localparam int unsigned AmtW     = 16;
  localparam int unsigned PosW     = 25;
  localparam int unsigned IdleW    = 7;
  localparam int unsigned ContentW = 24;
  localparam int unsigned LineW    = 8;
  localparam int unsigned ScreenW  = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Wide working width for target arithmetic (goal plus page move)
  localparam int unsigned SumW = 30;
  // Working width for 4*pos + goal
  localparam int unsigned EaseW = 28;

  // Request codes
  localparam logic [ReqW-1:0] REQ_TICK   = 3'd0;
  localparam logic [ReqW-1:0] REQ_PIXELS = 3'd1;
  localparam logic [ReqW-1:0] REQ_LINES  = 3'd2;
  localparam logic [ReqW-1:0] REQ_PAGES  = 3'd3;
  localparam logic [ReqW-1:0] REQ_HOME   = 3'd4;
  localparam logic [ReqW-1:0] REQ_END    = 3'd5;
  localparam logic [ReqW-1:0] REQ_WHEEL  = 3'd6;

  // Configuration register indices
  localparam logic [CfgIdxW-1:0] CFG_CONTENT_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LINE_HEIGHT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_HEIGHT  = 2'd2;

  // Configuration reset values
  localparam logic [ContentW-1:0] CONTENT_RST = 24'd0;
  localparam logic [LineW-1:0]    LINE_RST    = 8'd16;
  localparam logic [ScreenW-1:0]  SCREEN_RST  = 12'd480;

  // Idle tick saturation point
  localparam logic [IdleW-1:0] IDLE_LIMIT = 7'd120;

  // ceil(2^32 / 5): floor(n * RECIP5 / 2^32) == floor(n / 5) for n < 2^30
  localparam int unsigned  RecipW     = 30;
  localparam int unsigned  RecipShift = 32;
  localparam logic [RecipW-1:0] RECIP5 = 30'h3333_3334;

endpackage

// ===== rtl/smooth_scroll_position_easer_top.sv =====
// ----------------------------------------------------------------------------
// smooth_scroll_position_easer_top - scroll target and eased position
// Takes one beat per cycle while the result side does not stall: a command
// beat moves and clamps the scroll target, a tick beat eases the position
// one fifth of the way toward it. Each input beat yields exactly one result
// beat after two register stages (input register, then result register);
// the sustained rate is one beat per clock, as the position, target and
// idle-count registers update for each beat. A stall on the result side
// holds both stages. Configuration writes take effect at once and do not
// re-clamp the target; the next command does.
// ----------------------------------------------------------------------------
module smooth_scroll_position_easer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [sspe_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [sspe_pkg::CfgDataW-1:0]        cfg_data,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sspe_pkg::ReqW-1:0]            req_type,
  input  logic signed [sspe_pkg::AmtW-1:0]     amount,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sspe_pkg::PosW-1:0]     position,
  output logic signed [sspe_pkg::PosW-1:0]     target,
  output logic                                 active,
  output logic [sspe_pkg::IdleW-1:0]           idle_ticks
);
  import sspe_pkg::*;

  // Configuration registers
  logic [ContentW-1:0] content_size;
  logic [LineW-1:0]    line_height;
  logic [ScreenW-1:0]  page_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      content_size <= CONTENT_RST;
      line_height  <= LINE_RST;
      page_height  <= SCREEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONTENT_SIZE: content_size <= cfg_data[ContentW-1:0];
        CFG_LINE_HEIGHT:  line_height  <= cfg_data[LineW-1:0];
        CFG_PAGE_HEIGHT:  page_height  <= cfg_data[ScreenW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register is
  // free or being emptied this cycle.
  logic              s1_valid;
  logic [ReqW-1:0]   s1_type;
  logic signed [AmtW-1:0] s1_amount;
  logic              s1_move;
  logic              in_take;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_type   <= req_type;
      s1_amount <= amount;
    end
  end

  // State registers
  logic signed [PosW-1:0] scroll_pos;
  logic signed [PosW-1:0] scroll_goal;
  logic [IdleW-1:0]       still_count;

  logic signed [PosW-1:0] scroll_pos_next;
  logic signed [PosW-1:0] scroll_goal_next;
  logic [IdleW-1:0]       still_count_next;
  logic                   active_next;

  // Upper clamp bound: content size minus one line (may be negative)
  logic signed [SumW-1:0] top;
  assign top = $signed({{(SumW-ContentW){1'b0}}, content_size})
             - $signed({{(SumW-LineW){1'b0}}, line_height});

  // Target deltas for the move commands
  logic signed [AmtW+LineW:0]     line_prod;
  logic signed [AmtW+ScreenW:0]   page_prod;
  logic signed [AmtW:0]           wheel_neg;
  logic signed [AmtW:0]           wheel_half;
  logic signed [SumW-1:0]         amt_ext;
  logic signed [SumW-1:0]         lh_ext;

  assign line_prod  = s1_amount * $signed({1'b0, line_height});
  assign page_prod  = s1_amount * $signed({1'b0, page_height});
  assign wheel_neg  = -$signed({s1_amount[AmtW-1], s1_amount});
  // halve, truncating toward zero
  assign wheel_half = (wheel_neg + $signed({{AmtW{1'b0}}, wheel_neg[AmtW]})) >>> 1;
  assign amt_ext    = SumW'(s1_amount);
  assign lh_ext     = $signed({{(SumW-LineW){1'b0}}, line_height});

  // Raw target before clamping
  logic signed [SumW-1:0] goal_ext;
  logic signed [SumW-1:0] goal_raw;
  logic signed [SumW-1:0] goal_lo;
  logic signed [SumW-1:0] goal_clamped;

  assign goal_ext = SumW'(scroll_goal);

  always_comb begin
    case (s1_type)
      REQ_PIXELS: goal_raw = goal_ext + amt_ext;
      REQ_LINES:  goal_raw = goal_ext + SumW'(line_prod);
      REQ_PAGES:  goal_raw = goal_ext + SumW'(page_prod) - lh_ext;
      REQ_HOME:   goal_raw = '0;
      REQ_END:    goal_raw = top;
      REQ_WHEEL:  goal_raw = goal_ext + SumW'(wheel_half);
      default:    goal_raw = goal_ext;
    endcase
  end

  // Lower bound first, then the upper bound wins
  assign goal_lo      = (goal_raw < 0) ? '0 : goal_raw;
  assign goal_clamped = (goal_lo > top) ? top : goal_lo;

  // Easing: next = trunc((4*pos + goal) / 5), by reciprocal multiply on the
  // magnitude and a sign restore.
  logic signed [EaseW-1:0]           ease_sum;
  logic [EaseW-2:0]                  ease_mag;
  logic [EaseW-1+RecipW-1:0]         ease_prod;
  logic [PosW-1:0]                   ease_quot;
  logic signed [PosW-1:0]            ease_next;

  assign ease_sum  = (EaseW'(scroll_pos) <<< 2) + EaseW'(scroll_goal);
  assign ease_mag  = ease_sum[EaseW-1] ? (EaseW-1)'(-ease_sum) : ease_sum[EaseW-2:0];
  assign ease_prod = (EaseW-1+RecipW)'(ease_mag) * (EaseW-1+RecipW)'(RECIP5);
  assign ease_quot = ease_prod[RecipShift+PosW-1:RecipShift];
  assign ease_next = ease_sum[EaseW-1] ? -$signed(ease_quot) : $signed(ease_quot);

  // State update for the item in the input register
  always_comb begin
    scroll_pos_next  = scroll_pos;
    scroll_goal_next = scroll_goal;
    still_count_next = still_count;
    active_next      = 1'b1;
    unique case (s1_type)
      REQ_TICK: begin
        if (ease_next != scroll_pos) begin
          scroll_pos_next  = ease_next;
          still_count_next = '0;
        end else begin
          scroll_pos_next = scroll_goal;
          if (still_count < IDLE_LIMIT) begin
            still_count_next = still_count + 1'b1;
          end
          active_next = (still_count_next < IDLE_LIMIT);
        end
      end
      REQ_PIXELS, REQ_LINES, REQ_PAGES, REQ_HOME, REQ_END, REQ_WHEEL: begin
        scroll_goal_next = goal_clamped[PosW-1:0];
        still_count_next = '0;
      end
      default: begin
        // unused selector: nothing moves, result shows inactive
        active_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_pos  <= '0;
      scroll_goal <= '0;
      still_count <= IDLE_LIMIT;
    end else if (s1_move) begin
      scroll_pos  <= scroll_pos_next;
      scroll_goal <= scroll_goal_next;
      still_count <= still_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      position   <= scroll_pos_next;
      target     <= scroll_goal_next;
      active     <= active_next;
      idle_ticks <= still_count_next;
    end
  end

endmodule
